/* src/avm_pkg.sv */
// ============================================================================
// Accumulator machine execute unit package
// Shared types, opcode and mode codes, and the instruction decoder used by the
// execute unit, the arithmetic unit and the data memory.
// ============================================================================
package avm_pkg;

   localparam int AVM_DATA_BYTES = 1024;
   localparam int BYTE_W         = 8;
   localparam int WORD_W         = 32;

   localparam logic [7:0] OPC_NOP_A    = 8'h01;
   localparam logic [7:0] OPC_NOP_B    = 8'h02;
   localparam logic [7:0] OPC_READ_IN  = 8'h03;
   localparam logic [7:0] OPC_STORE    = 8'h04;
   localparam logic [7:0] OPC_LOAD     = 8'h05;
   localparam logic [7:0] OPC_LOAD_IMM = 8'h06;
   localparam logic [7:0] OPC_ADD      = 8'h07;
   localparam logic [7:0] OPC_SUB      = 8'h08;
   localparam logic [7:0] OPC_MUL      = 8'h09;
   localparam logic [7:0] OPC_DIV      = 8'h0a;
   localparam logic [7:0] OPC_NOP_C    = 8'h0b;
   localparam logic [7:0] OPC_NOP_D    = 8'h0c;
   localparam logic [7:0] OPC_CMP_MEM  = 8'h0d;
   localparam logic [7:0] OPC_CMP_IMM  = 8'h0e;
   localparam logic [7:0] OPC_JUMP     = 8'h10;
   localparam logic [7:0] OPC_NOP_E    = 8'h11;
   localparam logic [7:0] OPC_NOP_F    = 8'h12;
   localparam logic [7:0] OPC_HALT     = 8'hff;

   localparam logic [7:0] MODE_NONE   = 8'h01;
   localparam logic [7:0] MODE_MEM    = 8'h02;
   localparam logic [7:0] MODE_INPUT  = 8'h04;

   localparam logic [7:0] COND_GT     = 8'h01;
   localparam logic [7:0] COND_GE     = 8'h02;
   localparam logic [7:0] COND_LT     = 8'h03;
   localparam logic [7:0] COND_LE     = 8'h04;
   localparam logic [7:0] COND_EQ     = 8'h05;
   localparam logic [7:0] COND_NE     = 8'h06;
   localparam logic [7:0] COND_ALWAYS = 8'h07;
   localparam logic [7:0] COND_BACK   = 8'h08;

   localparam logic [WORD_W-1:0] STEP_INSTR = 32'd6;
   localparam logic [WORD_W-1:0] STEP_BAD   = 32'd1;
   localparam logic [WORD_W-1:0] STEP_NONE  = 32'd0;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_DIV_ZERO,
      STATUS_HALTED,
      STATUS_UNKNOWN
   } status_type;

   typedef enum logic [3:0] {
      ACT_DATA,
      ACT_HALT,
      ACT_BAD,
      ACT_NOP,
      ACT_IN_ST,
      ACT_ACC_ST,
      ACT_LD,
      ACT_LDI,
      ACT_ADD,
      ACT_SUB,
      ACT_MUL,
      ACT_DIV,
      ACT_CMP_M,
      ACT_CMP_I,
      ACT_JMP_M,
      ACT_JMP_B
   } action_type;

   typedef enum logic [1:0] {
      AOP_ADD,
      AOP_SUB,
      AOP_MUL,
      AOP_DIV
   } arith_op_type;

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_RUN,
      AR_FIX
   } arith_state_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_OFFSET,
      EX_ROUTE,
      EX_READ,
      EX_WRITE,
      EX_EXEC,
      EX_ALU,
      EX_FINISH
   } exec_state_type;

   typedef struct packed {
      logic               func;
      logic [7:0]         opcode;
      logic [7:0]         mode;
      logic signed [31:0] operand;
      logic signed [31:0] input_value;
      logic [9:0]         load_address;
      logic [7:0]         load_byte;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] pc_step;
      logic signed [31:0] accumulator_out;
      logic signed [31:0] compare_out;
   } rsp_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
      logic [WORD_W-1:0] remainder;
   } arith_rsp_type;

   function automatic logic jump_taken(input logic [7:0] cond, input logic signed [31:0] cmp);
      logic taken;
      case (cond)
         COND_GT: taken = (cmp > 32'sd0);
         COND_GE: taken = (cmp >= 32'sd0);
         COND_LT: taken = (cmp < 32'sd0);
         COND_LE: taken = (cmp <= 32'sd0);
         COND_EQ: taken = (cmp == 32'sd0);
         COND_NE: taken = (cmp != 32'sd0);
         default: taken = 1'b1;
      endcase
      return taken;
   endfunction

   function automatic action_type decode_action(
      input logic               func,
      input logic [7:0]         opcode,
      input logic [7:0]         mode,
      input logic signed [31:0] cmp
   );
      action_type act;
      act = ACT_BAD;
      if (!func) begin
         act = ACT_DATA;
      end else if (opcode == OPC_HALT) begin
         act = ACT_HALT;
      end else begin
         case (opcode)
            OPC_NOP_A, OPC_NOP_B, OPC_NOP_C, OPC_NOP_D, OPC_NOP_E, OPC_NOP_F: begin
               if (mode == MODE_NONE) act = ACT_NOP;
            end
            OPC_READ_IN: begin
               if (mode == MODE_INPUT) act = ACT_IN_ST;
            end
            OPC_STORE: begin
               if (mode == MODE_MEM) act = ACT_ACC_ST;
            end
            OPC_LOAD: begin
               if (mode == MODE_MEM) act = ACT_LD;
            end
            OPC_LOAD_IMM: begin
               if (mode == MODE_MEM) act = ACT_LDI;
            end
            OPC_ADD: begin
               if (mode == MODE_MEM) act = ACT_ADD;
            end
            OPC_SUB: begin
               if (mode == MODE_MEM) act = ACT_SUB;
            end
            OPC_MUL: begin
               if (mode == MODE_MEM) act = ACT_MUL;
            end
            OPC_DIV: begin
               if (mode == MODE_MEM) act = ACT_DIV;
            end
            OPC_CMP_MEM: begin
               if (mode == MODE_MEM) act = ACT_CMP_M;
            end
            OPC_CMP_IMM: begin
               if (mode == MODE_MEM) act = ACT_CMP_I;
            end
            OPC_JUMP: begin
               if (mode == COND_BACK) begin
                  act = ACT_JMP_B;
               end else if (mode >= COND_GT && mode <= COND_ALWAYS) begin
                  act = jump_taken(mode, cmp) ? ACT_JMP_M : ACT_NOP;
               end
            end
            default: act = ACT_BAD;
         endcase
      end
      return act;
   endfunction

   function automatic logic needs_memory(input action_type act);
      logic need;
      case (act)
         ACT_DATA, ACT_IN_ST, ACT_ACC_ST, ACT_LD, ACT_ADD, ACT_SUB, ACT_MUL,
         ACT_DIV, ACT_CMP_M, ACT_JMP_M: need = 1'b1;
         default: need = 1'b0;
      endcase
      return need;
   endfunction

endpackage

/* src/avm_data_mem.sv */
// ============================================================================
// Accumulator machine data memory
// Byte-wide data store with one write port and one registered read port.
// ============================================================================
module avm_data_mem #(
   parameter int DATA_BYTES = avm_pkg::AVM_DATA_BYTES
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DATA_BYTES)-1:0] wr_addr,
   input  logic [avm_pkg::BYTE_W-1:0]    wr_data,
   input  logic [$clog2(DATA_BYTES)-1:0] rd_addr,
   output logic [avm_pkg::BYTE_W-1:0]    rd_data
);
   import avm_pkg::*;

   logic [BYTE_W-1:0] mem [DATA_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/avm_arith.sv */
// ============================================================================
// Accumulator machine arithmetic unit
// One shared adder used for a single add or subtract, a shift-and-add
// multiply and a restoring signed divide, one bit per cycle.
// ============================================================================
module avm_arith (
   input  logic                         clock,
   input  logic                         reset,
   input  avm_pkg::arith_cmd_type       cmd,
   input  logic [avm_pkg::WORD_W-1:0]   a,
   input  logic [avm_pkg::WORD_W-1:0]   b,
   output avm_pkg::arith_rsp_type       rsp
);
   import avm_pkg::*;

   arith_state_type   state_ff, state_in;
   arith_op_type      op_ff, op_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] sha_ff, sha_in;
   logic [WORD_W-1:0] shb_ff, shb_in;
   logic              negq_ff, negq_in;
   logic              negr_ff, negr_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] result_ff, result_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W:0]   add_x;
   logic [WORD_W-1:0] add_y;
   logic              add_sub;
   logic [WORD_W+1:0] sum;

   always_comb begin
      add_x   = {1'b0, acc_ff};
      add_y   = shb_ff;
      add_sub = 1'b0;
      case (op_ff)
         AOP_ADD: add_sub = 1'b0;
         AOP_SUB: add_sub = 1'b1;
         AOP_MUL: add_y = sha_ff;
         AOP_DIV: begin
            add_x   = {acc_ff, sha_ff[WORD_W-1]};
            add_sub = 1'b1;
         end
         default: add_sub = 1'b0;
      endcase
      sum = {1'b0, add_x} + (add_sub ? ~{2'b00, add_y} : {2'b00, add_y})
            + {{(WORD_W+1){1'b0}}, add_sub};
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      sha_in    = sha_ff;
      shb_in    = shb_ff;
      negq_in   = negq_ff;
      negr_in   = negr_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      rem_in    = rem_ff;
      case (state_ff)
         AR_IDLE: begin
            if (cmd.start) begin
               op_in   = cmd.op;
               cnt_in  = '0;
               acc_in  = '0;
               sha_in  = a;
               shb_in  = b;
               negq_in = 1'b0;
               negr_in = 1'b0;
               case (cmd.op)
                  AOP_ADD, AOP_SUB: acc_in = a;
                  AOP_DIV: begin
                     sha_in  = a[WORD_W-1] ? -a : a;
                     shb_in  = b[WORD_W-1] ? -b : b;
                     negq_in = a[WORD_W-1] ^ b[WORD_W-1];
                     negr_in = a[WORD_W-1];
                  end
                  default: acc_in = '0;
               endcase
               state_in = AR_RUN;
            end
         end
         AR_RUN: begin
            case (op_ff)
               AOP_MUL: begin
                  if (shb_ff[0]) acc_in = sum[WORD_W-1:0];
                  sha_in = {sha_ff[WORD_W-2:0], 1'b0};
                  shb_in = {1'b0, shb_ff[WORD_W-1:1]};
               end
               AOP_DIV: begin
                  acc_in = sum[WORD_W+1] ? add_x[WORD_W-1:0] : sum[WORD_W-1:0];
                  sha_in = {sha_ff[WORD_W-2:0], ~sum[WORD_W+1]};
               end
               default: acc_in = sum[WORD_W-1:0];
            endcase
            cnt_in = cnt_ff + 5'd1;
            if (op_ff == AOP_ADD || op_ff == AOP_SUB || cnt_ff == 5'd31) begin
               state_in = AR_FIX;
            end
         end
         AR_FIX: begin
            done_in   = 1'b1;
            result_in = acc_ff;
            rem_in    = acc_ff;
            if (op_ff == AOP_DIV) begin
               result_in = negq_ff ? -sha_ff : sha_ff;
               rem_in    = negr_ff ? -acc_ff : acc_ff;
            end
            state_in = AR_IDLE;
         end
         default: state_in = AR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      sha_ff    <= sha_in;
      shb_ff    <= shb_in;
      negq_ff   <= negq_in;
      negr_ff   <= negr_in;
      result_ff <= result_in;
      rem_ff    <= rem_in;
   end

   assign rsp = '{done: done_ff, result: result_ff, remainder: rem_ff};

endmodule

/* src/accumulator_vm_execute_unit.sv */
// ============================================================================
// Accumulator machine execute unit
// Executes one instruction or one data-byte load per beat on the request
// channel and returns one beat on the response channel with the status,
// program-counter step, accumulator and compare value after the item.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The unit works on one item at a time and holds req_stall
// high from acceptance until the response is registered.
// Data loads, halt, no-ops, rejected items and the immediate load go straight
// to the response; the immediate compare and the backward jump use the shared
// adder; stores write four bytes. Memory loads, arithmetic, memory compare
// and taken conditional jumps first read four bytes; multiply and divide
// then run 32 iterations of the shared adder. When DATA_BYTES is not a
// power of two each memory address is first reduced on the same divider.
// A new request is taken the cycle after the previous response is registered.
// Reset clears the accumulator and compare value; data memory is not cleared.
// If the receiver stalls, the response is held in its output register and a
// finished item waits until the register is free.
// ============================================================================
module accumulator_vm_execute_unit #(
   parameter int DATA_BYTES = avm_pkg::AVM_DATA_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  avm_pkg::req_type req_beat,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output avm_pkg::rsp_type rsp_beat
);
   import avm_pkg::*;

   localparam int                ADDR_W    = $clog2(DATA_BYTES);
   localparam bit                ADDR_POW2 = (DATA_BYTES & (DATA_BYTES - 1)) == 0;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DATA_BYTES - 1);
   localparam logic [ADDR_W:0]   ADDR_SPAN = (ADDR_W + 1)'(DATA_BYTES);
   localparam logic [WORD_W-1:0] SPAN_WORD = WORD_W'(DATA_BYTES);

   exec_state_type    state_ff, state_in;
   action_type        act_ff, act_in;
   req_type           item_ff, item_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] cmp_ff, cmp_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] step_ff, step_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   arith_cmd_type     arith_cmd;
   arith_rsp_type     arith_rsp;
   logic [WORD_W-1:0] arith_a, arith_b;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [BYTE_W-1:0] mem_wr_data, mem_rd_data;

   action_type        act_dec;
   logic [WORD_W-1:0] raw_offset;
   logic [ADDR_W:0]   rem_fix;
   logic [ADDR_W-1:0] addr_next;

   avm_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .a     (arith_a),
      .b     (arith_b),
      .rsp   (arith_rsp)
   );

   avm_data_mem #(
      .DATA_BYTES (DATA_BYTES)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall  = (state_ff != EX_IDLE);
   assign act_dec    = decode_action(req_beat.func, req_beat.opcode, req_beat.mode, cmp_ff);
   assign raw_offset = req_beat.func ? req_beat.operand : WORD_W'(req_beat.load_address);
   assign addr_next  = (addr_ff == ADDR_LAST) ? '0 : addr_ff + ADDR_W'(1);
   assign rem_fix    = arith_rsp.remainder[ADDR_W:0] + ADDR_SPAN;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      item_in      = item_ff;
      acc_in       = acc_ff;
      cmp_in       = cmp_ff;
      word_in      = word_ff;
      step_in      = step_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      arith_cmd    = '{start: 1'b0, op: AOP_ADD};
      arith_a      = acc_ff;
      arith_b      = word_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = word_ff[WORD_W-1:WORD_W-BYTE_W];
      mem_rd_addr  = addr_ff;
      case (state_ff)
         EX_IDLE: begin
            if (req_valid) begin
               item_in   = req_beat;
               act_in    = act_dec;
               addr_in   = raw_offset[ADDR_W-1:0];
               status_in = STATUS_OK;
               case (act_dec)
                  ACT_DATA: step_in = STEP_NONE;
                  ACT_HALT: begin
                     step_in   = STEP_NONE;
                     status_in = STATUS_HALTED;
                  end
                  ACT_BAD: begin
                     step_in   = STEP_BAD;
                     status_in = STATUS_UNKNOWN;
                  end
                  default: step_in = STEP_INSTR;
               endcase
               state_in = EX_ROUTE;
               if (!ADDR_POW2 && needs_memory(act_dec)) begin
                  arith_cmd = '{start: 1'b1, op: AOP_DIV};
                  arith_a   = raw_offset;
                  arith_b   = SPAN_WORD;
                  state_in  = EX_OFFSET;
               end
            end
         end
         EX_OFFSET: begin
            if (arith_rsp.done) begin
               addr_in  = arith_rsp.remainder[WORD_W-1] ? rem_fix[ADDR_W-1:0]
                                                        : arith_rsp.remainder[ADDR_W-1:0];
               state_in = EX_ROUTE;
            end
         end
         EX_ROUTE: begin
            cnt_in   = '0;
            word_in  = acc_ff;
            state_in = EX_FINISH;
            case (act_ff)
               ACT_DATA: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = item_ff.load_byte;
               end
               ACT_IN_ST: begin
                  word_in  = item_ff.input_value;
                  state_in = EX_WRITE;
               end
               ACT_ACC_ST: state_in = EX_WRITE;
               ACT_LD, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_CMP_M, ACT_JMP_M: begin
                  state_in = EX_READ;
               end
               ACT_LDI: acc_in = item_ff.operand;
               ACT_CMP_I: begin
                  arith_cmd = '{start: 1'b1, op: AOP_SUB};
                  arith_a   = item_ff.operand;
                  arith_b   = acc_ff;
                  state_in  = EX_ALU;
               end
               ACT_JMP_B: begin
                  arith_cmd = '{start: 1'b1, op: AOP_SUB};
                  arith_a   = STEP_INSTR;
                  arith_b   = item_ff.operand;
                  state_in  = EX_ALU;
               end
               default: state_in = EX_FINISH;
            endcase
         end
         EX_WRITE: begin
            mem_wr_en = 1'b1;
            word_in   = {word_ff[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            addr_in   = addr_next;
            cnt_in    = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) state_in = EX_FINISH;
         end
         EX_READ: begin
            if (cnt_ff != 3'd0) word_in = {word_ff[WORD_W-BYTE_W-1:0], mem_rd_data};
            addr_in = addr_next;
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) state_in = EX_EXEC;
         end
         EX_EXEC: begin
            state_in        = EX_ALU;
            arith_cmd.start = 1'b1;
            case (act_ff)
               ACT_LD: begin
                  acc_in          = word_ff;
                  arith_cmd.start = 1'b0;
                  state_in        = EX_FINISH;
               end
               ACT_ADD: arith_cmd.op = AOP_ADD;
               ACT_SUB: arith_cmd.op = AOP_SUB;
               ACT_MUL: arith_cmd.op = AOP_MUL;
               ACT_DIV: begin
                  arith_cmd.op = AOP_DIV;
                  if (word_ff == '0) begin
                     status_in       = STATUS_DIV_ZERO;
                     arith_cmd.start = 1'b0;
                     state_in        = EX_FINISH;
                  end
               end
               ACT_CMP_M: begin
                  arith_cmd.op = AOP_SUB;
                  arith_a      = word_ff;
                  arith_b      = acc_ff;
               end
               ACT_JMP_M: begin
                  arith_cmd.op = AOP_ADD;
                  arith_a      = STEP_INSTR;
                  arith_b      = word_ff;
               end
               default: begin
                  arith_cmd.start = 1'b0;
                  state_in        = EX_FINISH;
               end
            endcase
         end
         EX_ALU: begin
            if (arith_rsp.done) begin
               state_in = EX_FINISH;
               case (act_ff)
                  ACT_CMP_M, ACT_CMP_I: cmp_in  = arith_rsp.result;
                  ACT_JMP_M, ACT_JMP_B: step_in = arith_rsp.result;
                  default:              acc_in  = arith_rsp.result;
               endcase
            end
         end
         EX_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status:          status_ff,
                                pc_step:         step_ff,
                                accumulator_out: acc_ff,
                                compare_out:     cmp_ff};
               state_in     = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         cmp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         cmp_ff       <= cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      item_ff   <= item_in;
      word_ff   <= word_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule
